// ===== rtl/quaternion_vector_rotate_core_assert.svh =====
// assertion macros for the quaternion rotate core
`ifndef QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH

// implication checked at every edge outside reset
`define QVR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qvr: port assertion failed");

// signal must hold across a stalled cycle
`define QVR_ASSERT_HOLD(lbl, cond, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error("qvr: stalled result changed");

`endif

// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// shared types and constants of the quaternion rotate core
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned DivSteps   = 16;
  localparam int unsigned NumW       = 51;
  localparam int unsigned DenW       = 34;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] v_x;
    logic signed [15:0] v_y;
    logic signed [15:0] v_z;
    logic               ident;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic               ident;
    logic signed [15:0] v_x;
    logic signed [15:0] v_y;
    logic signed [15:0] v_z;
  } side_t;

endpackage

// ===== rtl/quaternion_vector_rotate_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// rotates a 3d integer vector by an unnormalized q2.14 quaternion
// ----------------------------------------------------------------------------
// takes one item (q_w..q_z in q2.14, v_x..v_z as integers) per cycle and
// returns r = q v q* / |q|^2 rounded to nearest, ties away from zero; an
// all-zero quaternion passes v through and raises was_identity. throughput
// is one item per clock while the output is not stalled; an accepted item
// passes through the input register (loaded at the accepting edge), the
// queue, four product/sum stages, the operand load, sixteen restoring
// divide steps and the output register; the divider pipeline resolves one
// quotient bit per stage. a four entry queue lets the input side keep
// taking items while the output is stalled; stall_o rises only once that
// queue and the input register fill.
module quaternion_vector_rotate_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] q_w_i,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_y_i,
  input  logic signed [15:0] q_z_i,
  input  logic signed [15:0] v_x_i,
  input  logic signed [15:0] v_y_i,
  input  logic signed [15:0] v_z_i,
  // result channel
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [16:0] r_x_o,
  output logic signed [16:0] r_y_o,
  output logic signed [16:0] r_z_o,
  output logic               was_identity_o
);

  qvr_pkg::item_t  push_item, head_item;
  qvr_pkg::qstat_t qstat;
  logic            push, pop;

  // front: input register and identity check
  qvr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .q_w_i   (q_w_i),
    .q_x_i   (q_x_i),
    .q_y_i   (q_y_i),
    .q_z_i   (q_z_i),
    .v_x_i   (v_x_i),
    .v_y_i   (v_y_i),
    .v_z_i   (v_z_i),
    .qstat_i (qstat),
    .push_o  (push),
    .item_o  (push_item)
  );

  // decoupling queue
  qvr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .qstat_o (qstat)
  );

  // back: arithmetic pipeline, advances whenever the output slot frees
  qvr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head_item),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .r_x_o          (r_x_o),
    .r_y_o          (r_y_o),
    .r_z_o          (r_z_o),
    .was_identity_o (was_identity_o)
  );

endmodule

// ===== rtl/qvr_front.sv =====
// ----------------------------------------------------------------------------
// qvr_front
// input register; flags a zero quaternion as identity
// ----------------------------------------------------------------------------
module qvr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic signed [15:0]  q_w_i,
  input  logic signed [15:0]  q_x_i,
  input  logic signed [15:0]  q_y_i,
  input  logic signed [15:0]  q_z_i,
  input  logic signed [15:0]  v_x_i,
  input  logic signed [15:0]  v_y_i,
  input  logic signed [15:0]  v_z_i,
  input  qvr_pkg::qstat_t     qstat_i,
  output logic                push_o,
  output qvr_pkg::item_t      item_o
);

  logic           f_v_q, f_v_d;
  qvr_pkg::item_t f_q, f_d;
  logic           accept;

  assign stall_o = f_v_q && qstat_i.full;
  assign accept  = valid_i && !stall_o;
  assign push_o  = f_v_q && !qstat_i.full;
  assign item_o  = f_q;

  always_comb begin
    f_d       = f_q;
    f_d.q_w   = q_w_i;
    f_d.q_x   = q_x_i;
    f_d.q_y   = q_y_i;
    f_d.q_z   = q_z_i;
    f_d.v_x   = v_x_i;
    f_d.v_y   = v_y_i;
    f_d.v_z   = v_z_i;
    // all-zero quaternion has n == 0
    f_d.ident = (q_w_i == '0) && (q_x_i == '0) && (q_y_i == '0) && (q_z_i == '0);
    if (accept) begin
      f_v_d = 1'b1;
    end else if (push_o) begin
      f_v_d = 1'b0;
    end else begin
      f_v_d = f_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= f_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q <= f_d;
    end
  end

endmodule

// ===== rtl/qvr_queue.sv =====
// ----------------------------------------------------------------------------
// qvr_queue
// small fifo between front and back
// ----------------------------------------------------------------------------
module qvr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qvr_pkg::item_t  item_i,
  input  logic            pop_i,
  output qvr_pkg::item_t  item_o,
  output qvr_pkg::qstat_t qstat_o
);

  qvr_pkg::item_t                   mem_q [qvr_pkg::QueueDepth];
  logic [qvr_pkg::QueuePtrW-1:0]    wr_q, rd_q;
  logic [qvr_pkg::QueuePtrW:0]      cnt_q;
  logic                             do_push, do_pop;

  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == (qvr_pkg::QueuePtrW+1)'(qvr_pkg::QueueDepth));
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign item_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/qvr_back.sv =====
// ----------------------------------------------------------------------------
// qvr_back
// hamilton products, pipelined rounding divide and output register
// ----------------------------------------------------------------------------
module qvr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qvr_pkg::item_t      item_i,
  input  qvr_pkg::qstat_t     qstat_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                stall_i,
  output logic signed [16:0]  r_x_o,
  output logic signed [16:0]  r_y_o,
  output logic signed [16:0]  r_z_o,
  output logic                was_identity_o
);

  localparam int unsigned NS = qvr_pkg::DivSteps;

  logic en;

  // stage 1: 16x16 products and squares
  logic               s1_v_q;
  qvr_pkg::item_t     s1_it_q;
  logic signed [31:0] p_q [12];
  logic signed [31:0] sq_q [4];

  // stage 2: t = q * (0, v) and n
  logic               s2_v_q;
  qvr_pkg::item_t     s2_it_q;
  logic signed [33:0] tw_q, tx_q, ty_q, tz_q;
  logic [32:0]        n2_q;

  // stage 3: t times q
  logic               s3_v_q;
  qvr_pkg::side_t     s3_sd_q;
  logic [32:0]        n3_q;
  logic signed [49:0] m_q [12];

  // stage 4: vector part of s
  logic               s4_v_q;
  qvr_pkg::side_t     s4_sd_q;
  logic [32:0]        n4_q;
  logic signed [51:0] s_q [3];

  // divider stages, index 0 is the loaded numerator
  logic                                 dv_v_q  [NS+1];
  qvr_pkg::side_t                       dv_sd_q [NS+1];
  logic [qvr_pkg::DenW-1:0]             dv_den_q[NS+1];
  logic [2:0]                           dv_neg_q[NS+1];
  logic [2:0][qvr_pkg::NumW-1:0]        dv_rem_q[NS+1];
  logic [2:0][NS-1:0]                   dv_quo_q[NS+1];

  logic               o_v_q;
  logic signed [16:0] o_x_q, o_y_q, o_z_q;
  logic               o_id_q;

  assign en    = !o_v_q || !stall_i;
  assign pop_o = en && !qstat_i.empty;

  assign valid_o        = o_v_q;
  assign r_x_o          = o_x_q;
  assign r_y_o          = o_y_q;
  assign r_z_o          = o_z_q;
  assign was_identity_o = o_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      dv_v_q[0] <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (en) begin
      s1_v_q <= !qstat_i.empty;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      dv_v_q[0] <= s4_v_q;
      o_v_q  <= dv_v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      s1_it_q <= item_i;
      p_q[0]  <= item_i.q_x * item_i.v_x;
      p_q[1]  <= item_i.q_y * item_i.v_y;
      p_q[2]  <= item_i.q_z * item_i.v_z;
      p_q[3]  <= item_i.q_w * item_i.v_x;
      p_q[4]  <= item_i.q_y * item_i.v_z;
      p_q[5]  <= item_i.q_z * item_i.v_y;
      p_q[6]  <= item_i.q_w * item_i.v_y;
      p_q[7]  <= item_i.q_x * item_i.v_z;
      p_q[8]  <= item_i.q_z * item_i.v_x;
      p_q[9]  <= item_i.q_w * item_i.v_z;
      p_q[10] <= item_i.q_x * item_i.v_y;
      p_q[11] <= item_i.q_y * item_i.v_x;
      sq_q[0] <= item_i.q_w * item_i.q_w;
      sq_q[1] <= item_i.q_x * item_i.q_x;
      sq_q[2] <= item_i.q_y * item_i.q_y;
      sq_q[3] <= item_i.q_z * item_i.q_z;

      // stage 2
      s2_it_q <= s1_it_q;
      tw_q <= -34'(p_q[0]) - 34'(p_q[1]) - 34'(p_q[2]);
      tx_q <=  34'(p_q[3]) + 34'(p_q[4]) - 34'(p_q[5]);
      ty_q <=  34'(p_q[6]) - 34'(p_q[7]) + 34'(p_q[8]);
      tz_q <=  34'(p_q[9]) + 34'(p_q[10]) - 34'(p_q[11]);
      n2_q <= 33'(unsigned'(sq_q[0])) + 33'(unsigned'(sq_q[1]))
            + 33'(unsigned'(sq_q[2])) + 33'(unsigned'(sq_q[3]));

      // stage 3
      s3_sd_q <= '{ident: s2_it_q.ident, v_x: s2_it_q.v_x,
                   v_y: s2_it_q.v_y, v_z: s2_it_q.v_z};
      n3_q    <= n2_q;
      m_q[0]  <= tw_q * s2_it_q.q_x;
      m_q[1]  <= tx_q * s2_it_q.q_w;
      m_q[2]  <= ty_q * s2_it_q.q_z;
      m_q[3]  <= tz_q * s2_it_q.q_y;
      m_q[4]  <= tw_q * s2_it_q.q_y;
      m_q[5]  <= tx_q * s2_it_q.q_z;
      m_q[6]  <= ty_q * s2_it_q.q_w;
      m_q[7]  <= tz_q * s2_it_q.q_x;
      m_q[8]  <= tw_q * s2_it_q.q_z;
      m_q[9]  <= tx_q * s2_it_q.q_y;
      m_q[10] <= ty_q * s2_it_q.q_x;
      m_q[11] <= tz_q * s2_it_q.q_w;

      // stage 4: s = t * conj(q)
      s4_sd_q <= s3_sd_q;
      n4_q    <= n3_q;
      s_q[0]  <= -52'(m_q[0]) + 52'(m_q[1]) - 52'(m_q[2]) + 52'(m_q[3]);
      s_q[1]  <= -52'(m_q[4]) + 52'(m_q[5]) + 52'(m_q[6]) - 52'(m_q[7]);
      s_q[2]  <= -52'(m_q[8]) - 52'(m_q[9]) + 52'(m_q[10]) + 52'(m_q[11]);
    end
  end

  // load: numerator 2|s| + n, denominator 2n, gives round half away from zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_sd_q[0]  <= s4_sd_q;
      dv_den_q[0] <= {n4_q, 1'b0};
      dv_quo_q[0] <= '0;
      for (int l = 0; l < 3; l++) begin
        dv_neg_q[0][l] <= s_q[l][51];
        dv_rem_q[0][l] <= qvr_pkg::NumW'(
                            {(s_q[l][51] ? 52'(-s_q[l]) : 52'(s_q[l])), 1'b0}
                            + qvr_pkg::NumW'(n4_q));
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_div
    localparam int unsigned Sh = NS - 1 - j;
    logic [2:0][qvr_pkg::NumW-1:0] rem_d;
    logic [2:0][NS-1:0]            quo_d;
    logic [qvr_pkg::NumW-1:0]      dsh;

    assign dsh = qvr_pkg::NumW'(dv_den_q[j]) << Sh;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_d[l] = dv_rem_q[j][l];
        quo_d[l] = dv_quo_q[j][l];
        if (dv_rem_q[j][l] >= dsh) begin
          rem_d[l]     = dv_rem_q[j][l] - dsh;
          quo_d[l][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_sd_q[j+1]  <= dv_sd_q[j];
        dv_den_q[j+1] <= dv_den_q[j];
        dv_neg_q[j+1] <= dv_neg_q[j];
        dv_rem_q[j+1] <= rem_d;
        dv_quo_q[j+1] <= quo_d;
      end
    end
  end

  // output register: sign restore or pass-through
  always_ff @(posedge clk_i) begin
    if (en) begin
      o_id_q <= dv_sd_q[NS].ident;
      if (dv_sd_q[NS].ident) begin
        o_x_q <= 17'(dv_sd_q[NS].v_x);
        o_y_q <= 17'(dv_sd_q[NS].v_y);
        o_z_q <= 17'(dv_sd_q[NS].v_z);
      end else begin
        o_x_q <= dv_neg_q[NS][0] ? -signed'({1'b0, dv_quo_q[NS][0]})
                                 :  signed'({1'b0, dv_quo_q[NS][0]});
        o_y_q <= dv_neg_q[NS][1] ? -signed'({1'b0, dv_quo_q[NS][1]})
                                 :  signed'({1'b0, dv_quo_q[NS][1]});
        o_z_q <= dv_neg_q[NS][2] ? -signed'({1'b0, dv_quo_q[NS][2]})
                                 :  signed'({1'b0, dv_quo_q[NS][2]});
      end
    end
  end

endmodule

// ===== rtl/qvr_checker.sv =====
// ----------------------------------------------------------------------------
// qvr_sva_checker
// port-level checks of the quaternion rotate core
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_core_assert.svh"

module qvr_sva_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_o,
  input logic               stall_i,
  input logic signed [16:0] r_x_o,
  input logic signed [16:0] r_y_o,
  input logic signed [16:0] r_z_o,
  input logic               was_identity_o
);

  // a stalled result stays offered and its r_x_o stays unchanged
  `QVR_ASSERT_HOLD(a_out_hold, valid_o && stall_i, valid_o)
  `QVR_ASSERT_HOLD(a_out_stable, valid_o && stall_i, r_x_o)

  // a rotation keeps the length of v, which rounds to at most 56756
  `QVR_ASSERT_IMPL(a_rx_range, valid_o, (r_x_o <= 17'sd56756) && (r_x_o >= -17'sd56756))

  // pass-through results are plain sign-extended 16-bit values
  `QVR_ASSERT_IMPL(a_ident_narrow, valid_o && was_identity_o,
                   (r_x_o[16] == r_x_o[15]) && (r_y_o[16] == r_y_o[15]) &&
                   (r_z_o[16] == r_z_o[15]))

endmodule

bind quaternion_vector_rotate_core qvr_sva_checker u_qvr_checker (.*);
